[design/ascs_pkg.sv]
// Shared types, constants and constant tables for the adaptive step size controller.
// No dependencies.
`default_nettype none
package ascs_pkg;

    localparam int LOG_FRAC_BITS = 24;
    localparam int LOG_W         = 6 + LOG_FRAC_BITS;
    localparam int DIFF_W        = LOG_W + 1;
    localparam int PROD_W        = DIFF_W + 16;
    localparam int SUM_W         = PROD_W + 2;
    localparam int EXP_IDX_W     = $clog2(LOG_FRAC_BITS);
    localparam int LCNT_W        = $clog2(6 + LOG_FRAC_BITS);
    localparam int CNT_W         = 6;

    localparam logic [LCNT_W-1:0] LCNT_LAST = LCNT_W'(6 + LOG_FRAC_BITS - 1);
    localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(5);
    localparam logic [CNT_W-1:0]  EXP_LAST  = CNT_W'(LOG_FRAC_BITS - 1);

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_REJECT = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        CFG_TOLERANCE = 3'd0,
        CFG_SAFETY    = 3'd1,
        CFG_OFFSET    = 3'd2,
        CFG_GAIN_CUR  = 3'd3,
        CFG_GAIN_PREV = 3'd4,
        CFG_GAIN_OLD  = 3'd5,
        CFG_MIN_RATIO = 3'd6,
        CFG_MAX_RATIO = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        LS_TOL = 3'd0,
        LS_E0  = 3'd1,
        LS_E1  = 3'd2,
        LS_E2  = 3'd3,
        LS_SF  = 3'd4
    } log_sel_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [63:0] initial_step;
        logic [63:0] error_estimate;
    } in_req_t;

    typedef struct packed {
        logic [63:0] next_step;
        logic [63:0] step_taken;
        logic        accepted;
    } out_req_t;

    typedef struct packed {
        logic             load;
        logic             log_start;
        log_sel_t         log_sel;
        logic             log_take;
        logic             mul;
        logic             acc;
        logic             exp_init;
        logic             exp_step;
        logic             exp_fin;
        logic             sc_hi;
        logic             sc_lo;
        logic             sc_fin;
        logic             div_step;
        logic             div_fix;
        logic             div_fin;
        logic             res_load;
        logic [CNT_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic log_done;
        logic div_more;
    } sts_t;

    typedef logic [30:0] ctab_t [LOG_FRAC_BITS];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] vv;
        r  = '0;
        b  = 64'd1 << 62;
        vv = v;
        for (int j = 0; j < 32; j++) begin
            if (b > vv) b = b >> 2;
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 0) begin
                if (vv >= r + b) begin
                    vv = vv - (r + b);
                    r  = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // c[k] = 2^(2^-(k+1)) in Q30
    function automatic ctab_t make_ctab();
        ctab_t       t;
        logic [63:0] c;
        c = 64'd2 << 30;
        for (int k = 0; k < LOG_FRAC_BITS; k++) begin
            c    = isqrt64(c << 30);
            t[k] = c[30:0];
        end
        return t;
    endfunction

endpackage
`default_nettype wire

[design/ascs_log2.sv]
// Iterative fixed-point log2 unit: 6 normalize steps then one squaring per fraction bit.
// Depends on ascs_pkg.
`default_nettype none
module ascs_log2
    import ascs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [63:0]      x,
    output logic                  done,
    output logic [LOG_W-1:0]      result
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [LCNT_W-1:0]        cnt_reg, cnt_next;
    logic [63:0]              x_reg, x_next;
    logic [5:0]               p_reg, p_next;
    logic [30:0]              m_reg, m_next;
    logic [LOG_FRAC_BITS-1:0] frac_reg, frac_next;

    logic        top_zero;
    logic [63:0] x_sh;
    logic [5:0]  sh;
    logic [61:0] sq;
    logic [31:0] t;

    always_comb
    begin
        case (cnt_reg)
            LCNT_W'(0): begin top_zero = (x_reg[63:32] == '0); x_sh = x_reg << 32; sh = 6'd32; end
            LCNT_W'(1): begin top_zero = (x_reg[63:48] == '0); x_sh = x_reg << 16; sh = 6'd16; end
            LCNT_W'(2): begin top_zero = (x_reg[63:56] == '0); x_sh = x_reg << 8;  sh = 6'd8;  end
            LCNT_W'(3): begin top_zero = (x_reg[63:60] == '0); x_sh = x_reg << 4;  sh = 6'd4;  end
            LCNT_W'(4): begin top_zero = (x_reg[63:62] == '0); x_sh = x_reg << 2;  sh = 6'd2;  end
            LCNT_W'(5): begin top_zero = ~x_reg[63];           x_sh = x_reg << 1;  sh = 6'd1;  end
            default:    begin top_zero = 1'b0;                 x_sh = x_reg;       sh = 6'd0;  end
        endcase
    end

    assign sq = 62'(m_reg) * 62'(m_reg);
    assign t  = sq[61:30];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        p_next    = p_reg;
        m_next    = m_reg;
        frac_next = frac_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = (x == '0) ? 64'd1 : x;
            p_next    = 6'd63;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg < LCNT_W'(6)) begin
                if (top_zero) begin
                    x_next = x_sh;
                    p_next = p_reg - sh;
                end
                m_next = x_next[63:33];
            end else begin
                if (t[31]) begin
                    frac_next = {frac_reg[LOG_FRAC_BITS-2:0], 1'b1};
                    m_next    = t[31:1];
                end else begin
                    frac_next = {frac_reg[LOG_FRAC_BITS-2:0], 1'b0};
                    m_next    = t[30:0];
                end
            end
            if (cnt_reg == LCNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        p_reg    <= p_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
    end

    assign done   = done_reg;
    assign result = {p_reg, frac_reg};

endmodule
`default_nettype wire

[design/ascs_dpath.sv]
// Datapath: config registers, step and error history, log/exp arithmetic, scaling, divide by ten.
// Depends on ascs_pkg and ascs_log2.
`default_nettype none
module ascs_dpath
    import ascs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire in_req_t     in_data,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    output out_req_t         out_data
);

    localparam ctab_t C_TAB = make_ctab();
    localparam logic signed [SUM_W-1:0] TWO_F = SUM_W'(2) << LOG_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] E_TOP = SUM_W'(16) << LOG_FRAC_BITS;

    logic [63:0] tol_reg, off_reg;
    logic [15:0] sf_reg, min_reg, max_reg;
    logic signed [15:0] g0_reg, g1_reg, g2_reg;

    logic [63:0] step_reg, e0_reg, e1_reg, e2_reg, taken_reg;
    logic        acc_reg;
    logic [LOG_W-1:0] lt_reg, lsf_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg, e_reg;
    logic [30:0] eacc_reg;
    logic [LOG_FRAC_BITS-1:0] efrac_reg;
    logic [15:0] gf_reg;
    logic [47:0] hi_reg, lo_reg;
    logic [63:0] q_reg;
    out_req_t    out_reg;

    logic [63:0] err_sel;
    logic [64:0] sadd;
    logic [63:0] log_x;
    logic        log_done;
    logic [LOG_W-1:0] log_l;
    logic signed [15:0] gain;
    logic signed [SUM_W-1:0] e_next;
    logic [61:0] eprod;
    logic [45:0] eshift;
    logic [15:0] r0, r1, r2;
    logic [64:0] scsum;
    logic [63:0] q_step;
    logic [63:0] q_ten;
    logic [63:0] q_rem;
    logic        div_more;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tol_reg <= 64'd72057594038;
            sf_reg  <= 16'd14746;
            off_reg <= '0;
            g0_reg  <= 16'sd819;
            g1_reg  <= '0;
            g2_reg  <= '0;
            min_reg <= 16'd819;
            max_reg <= 16'd40960;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_TOLERANCE: tol_reg <= cfg_data;
                CFG_SAFETY:    sf_reg  <= cfg_data[15:0];
                CFG_OFFSET:    off_reg <= cfg_data;
                CFG_GAIN_CUR:  g0_reg  <= cfg_data[15:0];
                CFG_GAIN_PREV: g1_reg  <= cfg_data[15:0];
                CFG_GAIN_OLD:  g2_reg  <= cfg_data[15:0];
                CFG_MIN_RATIO: min_reg <= cfg_data[15:0];
                CFG_MAX_RATIO: max_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.log_sel)
            LS_E0:   begin err_sel = e0_reg; gain = g0_reg; end
            LS_E1:   begin err_sel = e1_reg; gain = g1_reg; end
            LS_E2:   begin err_sel = e2_reg; gain = g2_reg; end
            default: begin err_sel = e0_reg; gain = g0_reg; end
        endcase
    end

    assign sadd = {1'b0, err_sel} + {1'b0, off_reg};

    always_comb
    begin
        case (cmd.log_sel)
            LS_TOL:  log_x = tol_reg;
            LS_SF:   log_x = {48'd0, sf_reg};
            default: log_x = sadd[64] ? '1 : sadd[63:0];
        endcase
    end

    ascs_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_l)
    );

    // divide by ten: shift-add estimate of x * 0.8 / 8, then bump until remainder < 10
    always_comb
    begin
        case (cmd.idx)
            CNT_W'(0): q_step = (taken_reg >> 1) + (taken_reg >> 2);
            CNT_W'(1): q_step = q_reg + (q_reg >> 4);
            CNT_W'(2): q_step = q_reg + (q_reg >> 8);
            CNT_W'(3): q_step = q_reg + (q_reg >> 16);
            CNT_W'(4): q_step = q_reg + (q_reg >> 32);
            default:   q_step = q_reg >> 3;
        endcase
    end

    assign q_ten    = (q_reg << 3) + (q_reg << 1);
    assign q_rem    = taken_reg - q_ten;
    assign div_more = (q_rem >= 64'd10);

    assign sts = '{log_done: log_done, div_more: div_more};

    assign e_next = (sum_reg >>> 12) + SUM_W'($signed({1'b0, lsf_reg})) - TWO_F;
    assign eprod  = 62'(eacc_reg) * 62'(C_TAB[cmd.idx[EXP_IDX_W-1:0]]);
    assign eshift = {15'd0, eacc_reg} << e_reg[LOG_FRAC_BITS+3:LOG_FRAC_BITS];

    always_comb
    begin
        if (e_reg[SUM_W-1]) begin
            r0 = '0;
        end else if (e_reg >= E_TOP) begin
            r0 = 16'hFFFF;
        end else if (eshift[45:34] != '0) begin
            r0 = 16'hFFFF;
        end else begin
            r0 = eshift[33:18];
        end
        r1 = (r0 < min_reg) ? min_reg : r0;
        r2 = (r1 > max_reg) ? max_reg : r1;
    end

    assign scsum = {1'b0, hi_reg[43:0], 20'd0} + {29'd0, lo_reg[47:12]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg <= '0;
            e0_reg   <= '0;
            e1_reg   <= '0;
            e2_reg   <= '0;
        end else begin
            if (cmd.load) begin
                case (in_data.opcode)
                    OP_START: begin
                        step_reg <= in_data.initial_step;
                        e0_reg   <= tol_reg;
                        e1_reg   <= tol_reg;
                        e2_reg   <= tol_reg;
                    end
                    OP_UPDATE: begin
                        e2_reg <= e1_reg;
                        e1_reg <= e0_reg;
                        e0_reg <= in_data.error_estimate;
                    end
                    default: ;
                endcase
            end
            if (cmd.sc_fin) begin
                step_reg <= (hi_reg[47:44] != '0 || scsum[64]) ? '1 : scsum[63:0];
            end
            if (cmd.div_fin) begin
                step_reg <= q_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            taken_reg <= step_reg;
            acc_reg   <= (in_data.opcode == OP_UPDATE) &&
                         (in_data.error_estimate < tol_reg);
            sum_reg   <= '0;
        end
        if (cmd.log_take) begin
            case (cmd.log_sel)
                LS_TOL:  lt_reg <= log_l;
                LS_SF:   lsf_reg <= log_l;
                default: diff_reg <= $signed({1'b0, lt_reg}) - $signed({1'b0, log_l});
            endcase
        end
        if (cmd.mul) begin
            prod_reg <= diff_reg * gain;
        end
        if (cmd.acc) begin
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        end
        if (cmd.exp_init) begin
            e_reg     <= e_next;
            efrac_reg <= e_next[LOG_FRAC_BITS-1:0];
            eacc_reg  <= 31'd1 << 30;
        end
        if (cmd.exp_step) begin
            if (efrac_reg[LOG_FRAC_BITS-1]) eacc_reg <= eprod[60:30];
            efrac_reg <= efrac_reg << 1;
        end
        if (cmd.exp_fin) begin
            gf_reg <= r2;
        end
        if (cmd.sc_hi) begin
            hi_reg <= 48'(step_reg[63:32]) * 48'(gf_reg);
        end
        if (cmd.sc_lo) begin
            lo_reg <= 48'(step_reg[31:0]) * 48'(gf_reg);
        end
        if (cmd.div_step) begin
            q_reg <= q_step;
        end
        if (cmd.div_fix) begin
            q_reg <= q_reg + 64'd1;
        end
        if (cmd.res_load) begin
            out_reg.next_step  <= step_reg;
            out_reg.step_taken <= taken_reg;
            out_reg.accepted   <= acc_reg;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

[design/ascs_ctrl.sv]
// Controller state machine: sequences log, exp, scale and divide steps; owns the handshakes.
// Depends on ascs_pkg.
`default_nettype none
module ascs_ctrl
    import ascs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire opcode_t opcode,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    input  wire sts_t    sts,
    output cmd_t         cmd
);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_LOG_GO   = 14'b00000000000010,
        S_LOG_WAIT = 14'b00000000000100,
        S_MUL      = 14'b00000000001000,
        S_ACC      = 14'b00000000010000,
        S_EXP_INIT = 14'b00000000100000,
        S_EXP_STEP = 14'b00000001000000,
        S_EXP_FIN  = 14'b00000010000000,
        S_SC_HI    = 14'b00000100000000,
        S_SC_LO    = 14'b00001000000000,
        S_SC_FIN   = 14'b00010000000000,
        S_DIV      = 14'b00100000000000,
        S_DIV_FIN  = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t           state_reg, state_next;
    log_sel_t         sel_reg, sel_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg & out_stall;
        cmd         = '0;
        cmd.log_sel = sel_reg;
        cmd.idx     = cnt_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    case (opcode)
                        OP_UPDATE: begin
                            sel_next   = LS_TOL;
                            state_next = S_LOG_GO;
                        end
                        OP_REJECT: state_next = S_DIV;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_LOG_GO: begin
                cmd.log_start = 1'b1;
                state_next    = S_LOG_WAIT;
            end
            S_LOG_WAIT: begin
                if (sts.log_done) begin
                    cmd.log_take = 1'b1;
                    case (sel_reg)
                        LS_TOL: begin
                            sel_next   = LS_E0;
                            state_next = S_LOG_GO;
                        end
                        LS_SF:   state_next = S_EXP_INIT;
                        default: state_next = S_MUL;
                    endcase
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = S_LOG_GO;
                case (sel_reg)
                    LS_E0:   sel_next = LS_E1;
                    LS_E1:   sel_next = LS_E2;
                    default: sel_next = LS_SF;
                endcase
            end
            S_EXP_INIT: begin
                cmd.exp_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_EXP_STEP;
            end
            S_EXP_STEP: begin
                cmd.exp_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == EXP_LAST) state_next = S_EXP_FIN;
            end
            S_EXP_FIN: begin
                cmd.exp_fin = 1'b1;
                state_next  = S_SC_HI;
            end
            S_SC_HI: begin
                cmd.sc_hi  = 1'b1;
                state_next = S_SC_LO;
            end
            S_SC_LO: begin
                cmd.sc_lo  = 1'b1;
                state_next = S_SC_FIN;
            end
            S_SC_FIN: begin
                cmd.sc_fin = 1'b1;
                state_next = S_DONE;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) state_next = S_DIV_FIN;
            end
            S_DIV_FIN: begin
                if (sts.div_more) begin
                    cmd.div_fix = 1'b1;
                end else begin
                    cmd.div_fin = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (!ovalid_reg || !out_stall) begin
                    cmd.res_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= S_IDLE;
            sel_reg    <= LS_TOL;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;

endmodule
`default_nettype wire

[design/adaptive_step_size_controller.sv]
// Top level of the adaptive step size controller: controller plus datapath.
// Depends on ascs_pkg, ascs_ctrl, ascs_dpath.
//
// One request at a time. Start and the unused opcode go straight to the write-back;
// reject runs a shift-add estimate of the quotient, then corrections that add one while
// the remainder is at least ten, then the write-back. Update runs five log2 evaluations
// one after another in the single shared log2 unit (each: start, 6 normalize steps, one
// squaring per fraction bit and the hand-off), three multiply-accumulate pairs, then a
// 24-step exp2 sequence, the ratio clamp and step scaling. A finished result waits in
// the output register while the next request is taken.
`default_nettype none
module adaptive_step_size_controller
    import ascs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire in_req_t     in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output out_req_t         out_data,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    ascs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (in_data.opcode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ascs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire
